/* src/cdt_pkg.sv */
// ---------------------------------------------------------------------------
// Countdown timer package
// Shared types, event codes and time constants of the countdown timer.
// ---------------------------------------------------------------------------
package cdt_pkg;

    localparam int TIME_W   = 48;
    localparam int LAP_WRAP = 40;

    // Largest magnitude shown: just under thirty hours, in 1024 Hz ticks.
    localparam logic [TIME_W-1:0] CLAMP_TICKS = TIME_W'(30 * 60 * 60 * 1024 - 1);
    localparam logic [TIME_W-1:0] RESET_TICKS = TIME_W'(10 * 1024);

    typedef enum logic [2:0] {
        OP_TICK        = 3'd0,
        OP_ACTIVATE    = 3'd1,
        OP_LIGHT_REL   = 3'd2,
        OP_LIGHT_LONG  = 3'd3,
        OP_ALARM_PRESS = 3'd4,
        OP_MODE_REL    = 3'd5,
        OP_TIMEOUT     = 3'd6,
        OP_EXPIRY      = 3'd7
    } cdt_op_t;

    typedef enum logic [1:0] {
        NAV_STAY  = 2'd0,
        NAV_FIRST = 2'd1,
        NAV_NEXT  = 2'd2
    } cdt_nav_t;

    // Digit selector codes; off means the preset is not being edited.
    localparam logic [2:0] DIGIT_OFF      = 3'd0;
    localparam logic [2:0] DIGIT_SEC_ONES = 3'd1;
    localparam logic [2:0] DIGIT_SEC_TENS = 3'd2;
    localparam logic [2:0] DIGIT_MIN_ONES = 3'd3;
    localparam logic [2:0] DIGIT_MIN_TENS = 3'd4;
    localparam logic [2:0] DIGIT_HRS_ONES = 3'd5;
    localparam logic [2:0] DIGIT_HRS_TENS = 3'd6;

    typedef struct packed {
        cdt_op_t           operation;
        logic [TIME_W-1:0] now_ticks;
    } cdt_evt_t;

    typedef struct packed {
        logic [2:0]        edit_digit;
        logic              is_running;
        logic              repeat_on;
        logic [5:0]        lap_number;
        logic              overdue;
        logic [4:0]        view_hours;
        logic [5:0]        view_minutes;
        logic [5:0]        view_seconds;
        logic              alarm_pulse;
        cdt_nav_t          navigate;
        logic [TIME_W-1:0] wake_time;
        logic              wake_armed;
    } cdt_res_t;

    // State after one event, handed from the control logic to the display path.
    typedef struct packed {
        cdt_res_t          res;
        logic [TIME_W-1:0] now_ticks;
        logic [TIME_W-1:0] paused_left;
    } cdt_snap_t;

    typedef struct packed {
        logic [11:0] quot;
        logic [5:0]  rem;
    } cdt_div60_t;

endpackage

/* src/cdt_if.sv */
// ---------------------------------------------------------------------------
// Countdown timer channels
// Valid/ready channels for the event stream and the result stream.
// ---------------------------------------------------------------------------
interface cdt_evt_if;
    import cdt_pkg::*;

    logic     valid;
    logic     ready;
    cdt_evt_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cdt_res_if;
    import cdt_pkg::*;

    logic     valid;
    logic     ready;
    cdt_res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/cdt_state.sv */
// ---------------------------------------------------------------------------
// Countdown timer control state
// Holds the run state, preset and lap count, and applies one event per beat.
// ---------------------------------------------------------------------------
module cdt_state (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  cdt_pkg::cdt_evt_t    evt,
    output cdt_pkg::cdt_snap_t   snap
);
    import cdt_pkg::*;

    logic              running_reg, running_next;
    logic              repeat_reg, repeat_next;
    logic [2:0]        digit_reg, digit_next;
    logic [4:0]        hours_reg, hours_next;
    logic [5:0]        mins_reg, mins_next;
    logic [5:0]        secs_reg, secs_next;
    logic [5:0]        lap_reg, lap_next;
    logic [TIME_W-1:0] target_reg, target_next;
    logic [TIME_W-1:0] paused_reg, paused_next;
    logic              wake_reg, wake_next;
    logic [TIME_W-1:0] preset_reg, preset_next;

    logic              alarm;
    cdt_nav_t          nav;
    logic [6:0]        lap_plus;
    logic [5:0]        lap_inc;
    logic [TIME_W-1:0] target_lap;
    logic [TIME_W:0]   start_sum;
    logic [TIME_W-1:0] pause_left;
    logic              lap_due;
    logic [16:0]       preset_secs;
    logic [6:0]        sec_tens;
    logic [6:0]        mins_tens;
    logic [5:0]        hrs_tens;
    logic [5:0]        hrs_ones;

    // Next value of a decimal ones digit: nine wraps back to zero.
    function automatic logic [5:0] ones_step(input logic [5:0] v);
        logic [13:0] prod;
        logic [2:0]  quot;
        logic [5:0]  rem;
        prod = 14'(v) * 14'd205;
        quot = prod[13:11];
        rem  = v - 6'({quot, 3'b000} + {quot, 1'b0});
        return (rem == 6'd9) ? v - 6'd9 : v + 6'd1;
    endfunction

    assign lap_plus   = {1'b0, lap_reg} + 7'd1;
    assign lap_inc    = (lap_plus >= 7'(LAP_WRAP)) ? 6'(lap_plus - 7'(LAP_WRAP))
                                                   : lap_plus[5:0];
    assign target_lap = target_reg + preset_reg;
    assign start_sum  = {1'b0, evt.now_ticks} + {1'b0, paused_reg};
    assign pause_left = target_reg - evt.now_ticks;
    assign lap_due    = (target_reg <= evt.now_ticks);
    assign sec_tens   = {1'b0, secs_reg} + 7'd10;
    assign mins_tens  = {1'b0, mins_reg} + 7'd10;
    assign hrs_tens   = {1'b0, hours_reg} + 6'd10;
    assign hrs_ones   = ones_step({1'b0, hours_reg});

    always_comb
    begin
        running_next = running_reg;
        repeat_next  = repeat_reg;
        digit_next   = digit_reg;
        hours_next   = hours_reg;
        mins_next    = mins_reg;
        secs_next    = secs_reg;
        lap_next     = lap_reg;
        target_next  = target_reg;
        paused_next  = paused_reg;
        wake_next    = wake_reg;
        alarm        = 1'b0;
        nav          = NAV_STAY;

        case (evt.operation)
            OP_ACTIVATE:
            begin
                digit_next = DIGIT_OFF;
            end
            OP_LIGHT_REL:
            begin
                if (digit_reg != DIGIT_OFF)
                begin
                    paused_next = preset_reg;
                    lap_next    = 6'd0;
                    digit_next  = DIGIT_OFF;
                end
                else if (!running_reg)
                begin
                    if (paused_reg == preset_reg)
                    begin
                        digit_next = DIGIT_SEC_ONES;
                    end
                    else
                    begin
                        paused_next = preset_reg;
                        lap_next    = 6'd0;
                    end
                end
            end
            OP_LIGHT_LONG:
            begin
                repeat_next = !repeat_reg;
                if (running_reg && lap_due)
                begin
                    lap_next    = lap_inc;
                    target_next = target_lap;
                    wake_next   = 1'b1;
                end
            end
            OP_ALARM_PRESS:
            begin
                if (digit_reg != DIGIT_OFF)
                begin
                    case (digit_reg)
                        DIGIT_SEC_ONES: secs_next = ones_step(secs_reg);
                        DIGIT_SEC_TENS: secs_next = (sec_tens >= 7'd60) ? 6'(sec_tens - 7'd60)
                                                                          : sec_tens[5:0];
                        DIGIT_MIN_ONES: mins_next = ones_step(mins_reg);
                        DIGIT_MIN_TENS: mins_next = (mins_tens >= 7'd60) ? 6'(mins_tens - 7'd60)
                                                                           : mins_tens[5:0];
                        DIGIT_HRS_ONES: hours_next = hrs_ones[4:0];
                        DIGIT_HRS_TENS: hours_next = (hrs_tens >= 6'd30) ? 5'(hrs_tens - 6'd30)
                                                                          : hrs_tens[4:0];
                        default: ;
                    endcase
                end
                else if (running_reg)
                begin
                    running_next = 1'b0;
                    paused_next  = pause_left;
                    wake_next    = 1'b0;
                end
                else
                begin
                    running_next = 1'b1;
                    target_next  = start_sum[TIME_W-1:0];
                    // No carry out means the new target did not wrap past now.
                    if (!start_sum[TIME_W])
                    begin
                        wake_next = 1'b1;
                    end
                end
            end
            OP_MODE_REL:
            begin
                if (digit_reg != DIGIT_OFF)
                begin
                    digit_next = (digit_reg >= DIGIT_HRS_TENS) ? DIGIT_SEC_ONES
                                                              : digit_reg + 3'd1;
                end
                else
                begin
                    nav = NAV_NEXT;
                end
            end
            OP_TIMEOUT:
            begin
                if (!running_reg)
                begin
                    nav = NAV_FIRST;
                end
            end
            OP_EXPIRY:
            begin
                alarm     = 1'b1;
                wake_next = 1'b0;
                if (repeat_reg)
                begin
                    lap_next    = lap_inc;
                    target_next = target_lap;
                    wake_next   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // The preset in ticks is kept alongside the digits so that comparisons
    // and lap additions never wait on the multiplication.
    assign preset_secs = 17'(hours_next) * 17'd3600 + 17'(mins_next) * 17'd60
                       + 17'(secs_next);
    assign preset_next = TIME_W'({preset_secs, 10'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            repeat_reg  <= 1'b0;
            digit_reg   <= DIGIT_OFF;
            hours_reg   <= 5'd0;
            mins_reg    <= 6'd0;
            secs_reg    <= 6'd10;
            lap_reg     <= 6'd0;
            target_reg  <= '0;
            paused_reg  <= RESET_TICKS;
            wake_reg    <= 1'b0;
            preset_reg  <= RESET_TICKS;
        end
        else if (fire)
        begin
            running_reg <= running_next;
            repeat_reg  <= repeat_next;
            digit_reg   <= digit_next;
            hours_reg   <= hours_next;
            mins_reg    <= mins_next;
            secs_reg    <= secs_next;
            lap_reg     <= lap_next;
            target_reg  <= target_next;
            paused_reg  <= paused_next;
            wake_reg    <= wake_next;
            preset_reg  <= preset_next;
        end
    end

    always_comb
    begin
        snap.res.edit_digit   = digit_next;
        snap.res.is_running   = running_next;
        snap.res.repeat_on    = repeat_next;
        snap.res.lap_number   = lap_next;
        snap.res.overdue      = 1'b0;
        snap.res.view_hours   = hours_next;
        snap.res.view_minutes = mins_next;
        snap.res.view_seconds = secs_next;
        snap.res.alarm_pulse  = alarm;
        snap.res.navigate     = nav;
        snap.res.wake_time    = target_next;
        snap.res.wake_armed   = wake_next;
        snap.now_ticks        = evt.now_ticks;
        snap.paused_left      = paused_next;
    end

endmodule

/* src/cdt_view.sv */
// ---------------------------------------------------------------------------
// Countdown timer display path
// Turns the time left into sign, hours, minutes and seconds through registered stages.
// ---------------------------------------------------------------------------
module cdt_view (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cdt_pkg::cdt_snap_t snap,
    cdt_res_if.source          res
);
    import cdt_pkg::*;

    logic              v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic              rdy1, rdy2, rdy3, rdy4, rdy5;
    cdt_res_t          s1_res_reg, s2_res_reg, s3_res_reg, s4_res_reg, s5_res_reg;
    cdt_res_t          s3_res_next, s4_res_next, s5_res_next;
    logic [TIME_W-1:0] s1_now_reg, s1_paused_reg;
    logic [TIME_W-1:0] s2_left_reg, s2_left_next;
    logic [TIME_W-1:0] s2_mag, s2_clamped;
    logic [16:0]       s3_secs_reg;
    logic [10:0]       s4_mins_reg;
    cdt_div60_t        div_secs, div_mins;
    logic              editing3, editing4, editing5;

    // Quotient and remainder by sixty through a slightly low reciprocal;
    // the estimate is at most one short, fixed by one compare and subtract.
    function automatic cdt_div60_t div60(input logic [16:0] x);
        logic [32:0] prod;
        logic [11:0] q_est;
        logic [17:0] r_est;
        cdt_div60_t  d;
        prod  = 33'(x) * 33'd34952;
        q_est = prod[32:21];
        r_est = 18'(x) - (18'({q_est, 6'b0}) - 18'({q_est, 2'b0}));
        if (r_est >= 18'd60)
        begin
            d.quot = q_est + 12'd1;
            d.rem  = 6'(r_est - 18'd60);
        end
        else
        begin
            d.quot = q_est;
            d.rem  = r_est[5:0];
        end
        return d;
    endfunction

    assign rdy5     = !v5_reg || res.ready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign s2_left_next = s1_res_reg.is_running ? s1_res_reg.wake_time - s1_now_reg
                                                : s1_paused_reg;

    assign editing3   = (s2_res_reg.edit_digit != DIGIT_OFF);
    assign s2_mag     = s2_left_reg[TIME_W-1] ? TIME_W'(0) - s2_left_reg : s2_left_reg;
    assign s2_clamped = (s2_mag > CLAMP_TICKS) ? CLAMP_TICKS : s2_mag;

    always_comb
    begin
        s3_res_next = s2_res_reg;
        if (!editing3)
        begin
            s3_res_next.overdue = s2_left_reg[TIME_W-1];
        end
    end

    assign editing4 = (s3_res_reg.edit_digit != DIGIT_OFF);
    assign div_secs = div60(s3_secs_reg);

    always_comb
    begin
        s4_res_next = s3_res_reg;
        if (!editing4)
        begin
            s4_res_next.view_seconds = div_secs.rem;
        end
    end

    assign editing5 = (s4_res_reg.edit_digit != DIGIT_OFF);
    assign div_mins = div60({6'b0, s4_mins_reg});

    always_comb
    begin
        s5_res_next = s4_res_reg;
        if (!editing5)
        begin
            s5_res_next.view_minutes = div_mins.rem;
            s5_res_next.view_hours   = div_mins.quot[4:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_res_reg    <= snap.res;
            s1_now_reg    <= snap.now_ticks;
            s1_paused_reg <= snap.paused_left;
        end
        if (rdy2)
        begin
            s2_res_reg  <= s1_res_reg;
            s2_left_reg <= s2_left_next;
        end
        if (rdy3)
        begin
            s3_res_reg  <= s3_res_next;
            s3_secs_reg <= s2_clamped[26:10];
        end
        if (rdy4)
        begin
            s4_res_reg  <= s4_res_next;
            s4_mins_reg <= div_secs.quot[10:0];
        end
        if (rdy5)
        begin
            s5_res_reg <= s5_res_next;
        end
    end

    assign res.valid = v5_reg;
    assign res.data  = s5_res_reg;

endmodule

/* src/countdown_timer_with_auto_repeat_core.sv */
// ---------------------------------------------------------------------------
// Countdown timer with auto-repeat
// Event-driven countdown timer with preset editing, lap count and display view.
// ---------------------------------------------------------------------------
//  channel  direction  payload                         handshake
//  evt      in         operation, now_ticks            valid / ready
//  res      out        view, flags, lap, wake request  valid / ready
//
// One result beat for every event beat. A new event is taken every cycle
// while the output accepts results; an event passes through the input
// register, the state update and four display stages (subtract,
// magnitude and clamp, and two divisions by sixty) to the output.
// Each stage holds its beat while the stage after it is full and stalled, so events keep
// flowing until every stage is occupied. Reset clears the valid flags and
// restores a paused ten-second preset.
module countdown_timer_with_auto_repeat_core (
    input  logic      clk,
    input  logic      rst_n,
    cdt_evt_if.sink   evt,
    cdt_res_if.source res
);
    import cdt_pkg::*;

    logic      evt_valid_reg;
    cdt_evt_t  evt_data_reg;
    logic      view_ready;
    logic      fire;
    cdt_snap_t snap;

    assign evt.ready = !evt_valid_reg || view_ready;
    assign fire      = evt_valid_reg && view_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
        end
        else if (evt.ready)
        begin
            evt_valid_reg <= evt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.ready)
        begin
            evt_data_reg <= evt.data;
        end
    end

    cdt_state u_state (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .evt   (evt_data_reg),
        .snap  (snap)
    );

    cdt_view u_view (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (evt_valid_reg),
        .in_ready (view_ready),
        .snap     (snap),
        .res      (res)
    );

endmodule
